### hw/rtl/tac_pkg.sv
// shared types, constants and helpers for the texture tint and alpha classifier
package tac_pkg;

  localparam int MAX_PIXELS   = 16777216;
  localparam int OPAQUE_MIN   = 250;
  localparam int CLEAR_MAX    = 5;
  localparam int PART_WEIGHT  = 50;
  localparam int CLEAR_WEIGHT = 1000;

  localparam int CNT_W = $clog2(MAX_PIXELS + 1);
  localparam int TOT_W = $clog2(3 * MAX_PIXELS + 1);
  localparam int P50_W = $clog2(longint'(PART_WEIGHT) * longint'(MAX_PIXELS) + 1);
  localparam int C1K_W = $clog2(longint'(CLEAR_WEIGHT) * longint'(MAX_PIXELS) + 1);

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 9;
  localparam int FACTOR_W   = 9;

  localparam logic [FACTOR_W-1:0] UNIT = FACTOR_W'(256);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RED_FACTOR   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_GREEN_FACTOR = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_BLUE_FACTOR  = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_OPACITY_SCL  = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] CFG_OPACITY_SRC  = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] CFG_INVERT_SMP   = CFG_IDX_W'(5);

  // opacity source codes as written by software
  localparam logic [1:0] OPSRC_ONE     = 2'd0;
  localparam logic [1:0] OPSRC_SCALAR  = 2'd1;
  localparam logic [1:0] OPSRC_TEXTURE = 2'd2;

  typedef enum logic [1:0] {
    ASEL_ONE,
    ASEL_SCALAR,
    ASEL_TEXTURE
  } alpha_sel_t;

  typedef enum logic [1:0] {
    CLS_OPAQUE,
    CLS_CLEAR,
    CLS_PARTIAL
  } cls_t;

  typedef enum logic [1:0] {
    MODE_OPAQUE = 2'd0,
    MODE_MASK   = 2'd1,
    MODE_BLEND  = 2'd2
  } mode_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    cls_t       cls;
    logic       last;
  } tac_word_t;

  typedef struct packed {
    logic full;
    logic empty;
  } tac_fifo_stat_t;

  function automatic logic [FACTOR_W-1:0] sat_unit(input logic [CFG_DATA_W-1:0] v);
    logic [FACTOR_W-1:0] f;
    f = FACTOR_W'(v);
    return (f > UNIT) ? UNIT : f;
  endfunction

endpackage

### hw/rtl/tac_front.sv
// front end: config registers, tint and alpha datapath, alpha classification
module tac_front import tac_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            in_red,
  input  logic [7:0]            in_green,
  input  logic [7:0]            in_blue,
  input  logic [7:0]            in_alpha,
  input  logic [7:0]            in_opacity_sample,
  input  logic                  in_last_pixel,
  input  tac_fifo_stat_t        fifo_stat,
  output logic                  push,
  output tac_word_t             push_word
);

  logic [FACTOR_W-1:0] red_factor_r, green_factor_r, blue_factor_r, opacity_scale_r;
  logic [1:0]          opacity_source_r;
  logic                invert_sample_r;

  // stage 1
  logic       v1_r;
  logic [7:0] red1_r, grn1_r, blu1_r, a1_r, smp1_r;
  alpha_sel_t asel1_r;
  logic       last1_r;

  // stage 2
  logic      v2_r;
  tac_word_t word2_r;

  logic              adv1, adv2;
  logic [16:0]       red_prod, grn_prod, blu_prod, a1_prod;
  logic [7:0]        a1_opnd, smp_nxt;
  alpha_sel_t        asel_nxt;
  logic [15:0]       tex_prod;
  logic [16:0]       tex_div;
  logic [7:0]        alpha_fin;
  cls_t              cls_nxt;
  tac_word_t         word_nxt;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      red_factor_r     <= UNIT;
      green_factor_r   <= UNIT;
      blue_factor_r    <= UNIT;
      opacity_scale_r  <= UNIT;
      opacity_source_r <= OPSRC_ONE;
      invert_sample_r  <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_RED_FACTOR:   red_factor_r     <= sat_unit(cfg_data);
        CFG_GREEN_FACTOR: green_factor_r   <= sat_unit(cfg_data);
        CFG_BLUE_FACTOR:  blue_factor_r    <= sat_unit(cfg_data);
        CFG_OPACITY_SCL:  opacity_scale_r  <= sat_unit(cfg_data);
        CFG_OPACITY_SRC:  opacity_source_r <= cfg_data[1:0];
        CFG_INVERT_SMP:   invert_sample_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign push     = v2_r && !fifo_stat.full;
  assign adv2     = !v2_r || push;
  assign adv1     = !v1_r || adv2;
  assign in_ready = adv1;

  // stage 1: channel tints and the scaled alpha
  always_comb begin
    unique case (opacity_source_r)
      OPSRC_SCALAR:  asel_nxt = ASEL_SCALAR;
      OPSRC_TEXTURE: asel_nxt = ASEL_TEXTURE;
      default:       asel_nxt = ASEL_ONE;
    endcase
    a1_opnd  = (asel_nxt == ASEL_TEXTURE) ? in_alpha : 8'hFF;
    smp_nxt  = invert_sample_r ? ~in_opacity_sample : in_opacity_sample;
    red_prod = 17'(in_red) * 17'(red_factor_r);
    grn_prod = 17'(in_green) * 17'(green_factor_r);
    blu_prod = 17'(in_blue) * 17'(blue_factor_r);
    a1_prod  = 17'(a1_opnd) * 17'(opacity_scale_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv1) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      red1_r  <= red_prod[15:8];
      grn1_r  <= grn_prod[15:8];
      blu1_r  <= blu_prod[15:8];
      a1_r    <= a1_prod[15:8];
      smp1_r  <= smp_nxt;
      asel1_r <= asel_nxt;
      last1_r <= in_last_pixel;
    end
  end

  // stage 2: sample product, divide by 255, classify
  always_comb begin
    tex_prod = 16'(a1_r) * 16'(smp1_r);
    // exact floor(x/255) for x below 65280
    tex_div  = 17'(tex_prod) + 17'(tex_prod[15:8]) + 17'd1;
    unique case (asel1_r)
      ASEL_SCALAR:  alpha_fin = a1_r;
      ASEL_TEXTURE: alpha_fin = tex_div[15:8];
      default:      alpha_fin = 8'hFF;
    endcase
    priority if (alpha_fin >= 8'(OPAQUE_MIN)) begin
      cls_nxt = CLS_OPAQUE;
    end else if (alpha_fin <= 8'(CLEAR_MAX)) begin
      cls_nxt = CLS_CLEAR;
    end else begin
      cls_nxt = CLS_PARTIAL;
    end
    word_nxt.red   = red1_r;
    word_nxt.green = grn1_r;
    word_nxt.blue  = blu1_r;
    word_nxt.alpha = alpha_fin;
    word_nxt.cls   = cls_nxt;
    word_nxt.last  = last1_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv2) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv2) begin
      word2_r <= word_nxt;
    end
  end

  assign push_word = word2_r;

endmodule

### hw/rtl/tac_fifo.sv
// short word queue between the front end and the back end
module tac_fifo import tac_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  tac_word_t      push_word,
  input  logic           pop,
  output tac_word_t      pop_word,
  output tac_fifo_stat_t stat
);

  tac_word_t             mem_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [FIFO_CNT_W-1:0] cnt_r;

  function automatic logic [FIFO_PTR_W-1:0] ptr_inc(input logic [FIFO_PTR_W-1:0] p);
    return (p == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + FIFO_PTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= ptr_inc(wr_ptr_r);
      if (pop)  rd_ptr_r <= ptr_inc(rd_ptr_r);
      if (push && !pop) begin
        cnt_r <= cnt_r + FIFO_CNT_W'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - FIFO_CNT_W'(1);
      end
    end
  end

  assign pop_word   = mem_r[rd_ptr_r];
  assign stat.full  = (cnt_r == FIFO_CNT_W'(FIFO_DEPTH));
  assign stat.empty = (cnt_r == '0);

endmodule

### hw/rtl/tac_back.sv
// back end: running alpha counts, image alpha mode, output register
module tac_back import tac_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  input  tac_fifo_stat_t fifo_stat,
  input  tac_word_t      pop_word,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [7:0]     out_red,
  output logic [7:0]     out_green,
  output logic [7:0]     out_blue,
  output logic [7:0]     out_alpha,
  output logic           out_last,
  output logic [1:0]     out_alpha_mode
);

  logic [CNT_W-1:0] opq_r, clr_r, prt_r;
  logic [TOT_W-1:0] tot_r;
  // partial*50 and clear*1000 kept as running sums
  logic [P50_W-1:0] p50_r;
  logic [C1K_W-1:0] c1k_r;

  logic [CNT_W-1:0] opq_nxt, clr_nxt, prt_nxt;
  logic [TOT_W-1:0] tot_nxt;
  logic [P50_W-1:0] p50_nxt;
  logic [C1K_W-1:0] c1k_nxt;
  logic             b_opq, b_clr, b_prt;
  mode_t            mode_nxt;

  logic       out_valid_r, out_last_r;
  logic [7:0] out_red_r, out_green_r, out_blue_r, out_alpha_r;
  mode_t      out_mode_r;

  assign pop = !fifo_stat.empty && (!out_valid_r || out_ready);

  always_comb begin
    b_opq   = (pop_word.cls == CLS_OPAQUE)  && (opq_r < CNT_W'(MAX_PIXELS));
    b_clr   = (pop_word.cls == CLS_CLEAR)   && (clr_r < CNT_W'(MAX_PIXELS));
    b_prt   = (pop_word.cls == CLS_PARTIAL) && (prt_r < CNT_W'(MAX_PIXELS));
    opq_nxt = opq_r + CNT_W'(b_opq);
    clr_nxt = clr_r + CNT_W'(b_clr);
    prt_nxt = prt_r + CNT_W'(b_prt);
    tot_nxt = tot_r + TOT_W'(b_opq || b_clr || b_prt);
    p50_nxt = p50_r + (b_prt ? P50_W'(PART_WEIGHT) : '0);
    c1k_nxt = c1k_r + (b_clr ? C1K_W'(CLEAR_WEIGHT) : '0);
    priority if (!pop_word.last) begin
      mode_nxt = MODE_OPAQUE;
    end else if (prt_nxt == '0) begin
      mode_nxt = (clr_nxt != '0) ? MODE_MASK : MODE_OPAQUE;
    end else if ((C1K_W'(p50_nxt) <= C1K_W'(tot_nxt)) && (c1k_nxt >= C1K_W'(tot_nxt))) begin
      mode_nxt = MODE_MASK;
    end else begin
      mode_nxt = MODE_BLEND;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      opq_r <= '0;
      clr_r <= '0;
      prt_r <= '0;
      tot_r <= '0;
      p50_r <= '0;
      c1k_r <= '0;
    end else if (pop) begin
      if (pop_word.last) begin
        opq_r <= '0;
        clr_r <= '0;
        prt_r <= '0;
        tot_r <= '0;
        p50_r <= '0;
        c1k_r <= '0;
      end else begin
        opq_r <= opq_nxt;
        clr_r <= clr_nxt;
        prt_r <= prt_nxt;
        tot_r <= tot_nxt;
        p50_r <= p50_nxt;
        c1k_r <= c1k_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_red_r   <= pop_word.red;
      out_green_r <= pop_word.green;
      out_blue_r  <= pop_word.blue;
      out_alpha_r <= pop_word.alpha;
      out_last_r  <= pop_word.last;
      out_mode_r  <= mode_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_red        = out_red_r;
  assign out_green      = out_green_r;
  assign out_blue       = out_blue_r;
  assign out_alpha      = out_alpha_r;
  assign out_last       = out_last_r;
  assign out_alpha_mode = out_mode_r;

endmodule

### hw/rtl/texture_tint_alpha_classify.sv
// path: an accepted word moves on through the second front stage, the queue write
// and the output register to out_valid; it waits in the queue while output stalls
// throughput: one pixel per clock while out_ready is high, set by the two-stage
// front datapath and the back-end count update; four-entry queue absorbs stalls
// reset: synchronous active-low; clears pipeline, queue, counts and output valid,
// factors and scale to 1.0, opacity source and sample invert to zero
module texture_tint_alpha_classify import tac_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            in_red,
  input  logic [7:0]            in_green,
  input  logic [7:0]            in_blue,
  input  logic [7:0]            in_alpha,
  input  logic [7:0]            in_opacity_sample,
  input  logic                  in_last_pixel,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            out_red,
  output logic [7:0]            out_green,
  output logic [7:0]            out_blue,
  output logic [7:0]            out_alpha,
  output logic                  out_last,
  output logic [1:0]            out_alpha_mode
);

  tac_fifo_stat_t fifo_stat;
  tac_word_t      push_word, pop_word;
  logic           push, pop;

  tac_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_red           (in_red),
    .in_green         (in_green),
    .in_blue          (in_blue),
    .in_alpha         (in_alpha),
    .in_opacity_sample(in_opacity_sample),
    .in_last_pixel    (in_last_pixel),
    .fifo_stat        (fifo_stat),
    .push             (push),
    .push_word        (push_word)
  );

  tac_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_word(push_word),
    .pop      (pop),
    .pop_word (pop_word),
    .stat     (fifo_stat)
  );

  tac_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .fifo_stat     (fifo_stat),
    .pop_word      (pop_word),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_red       (out_red),
    .out_green     (out_green),
    .out_blue      (out_blue),
    .out_alpha     (out_alpha),
    .out_last      (out_last),
    .out_alpha_mode(out_alpha_mode)
  );

  // mode is only reported on the last word
  a_mode_only_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> out_alpha_mode == MODE_OPAQUE)
    else $error("alpha mode set on a word that is not last");

  // an opaque image means the last pixel itself was opaque
  a_opaque_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last && out_alpha_mode == MODE_OPAQUE |-> out_alpha >= 8'(OPAQUE_MIN))
    else $error("opaque mode with a non-opaque last pixel");

  // a word can only leave the queue when the queue holds one
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    fifo_stat.empty |-> !pop)
    else $error("pop from empty queue");

  a_reset_idle: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("output valid right after reset");

endmodule

### verif/texture_tint_alpha_classify_tb.sv
// testbench for the texture tint and alpha classifier: directed table, then random images
module texture_tint_alpha_classify_tb;
  import tac_pkg::*;

  // opacity source code with no meaning of its own, acts as full opacity
  localparam logic [1:0] OPSRC_SPARE = 2'd3;
  // register indexes that map to nothing
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_LO = CFG_IDX_W'(6);
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_HI = CFG_IDX_W'(7);

  localparam int OPAQUE_FLOOR = 250;
  localparam int CLEAR_CEIL   = 5;
  localparam int PIXEL_CAP    = 16777216;
  localparam int PHASES       = 8;
  localparam int PHASE_PIXELS = 180;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] red;
    logic [CFG_DATA_W-1:0] green;
    logic [CFG_DATA_W-1:0] blue;
    logic [CFG_DATA_W-1:0] scale;
    logic [CFG_DATA_W-1:0] src;
    logic [CFG_DATA_W-1:0] inv;
  } setting_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic [7:0] sample;
    logic       last;
  } pixel_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       last;
    mode_t      mode;
  } tinted_t;

  typedef struct packed {
    setting_t setting;
    pixel_t   pix;
    logic     typed;
    tinted_t  want;
  } dir_row_t;

  localparam setting_t SET_RESET = '{red: 256, green: 256, blue: 256, scale: 256,
                                     src: OPSRC_ONE, inv: 0};
  localparam setting_t SET_ZERO = '{red: 0, green: 0, blue: 0, scale: 0,
                                    src: OPSRC_SCALAR, inv: 0};
  localparam setting_t SET_SAT = '{red: 511, green: 511, blue: 511, scale: 511,
                                   src: OPSRC_TEXTURE, inv: 0};
  localparam setting_t SET_HALF_INV = '{red: 128, green: 128, blue: 128, scale: 256,
                                        src: OPSRC_TEXTURE, inv: 1};
  localparam setting_t SET_SPARE_SRC = '{red: 256, green: 1, blue: 257, scale: 300,
                                         src: OPSRC_SPARE, inv: 1};
  localparam setting_t SET_SCALAR = '{red: 256, green: 256, blue: 256, scale: 128,
                                      src: OPSRC_SCALAR, inv: 0};

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_ready;
  logic [7:0]            in_red;
  logic [7:0]            in_green;
  logic [7:0]            in_blue;
  logic [7:0]            in_alpha;
  logic [7:0]            in_opacity_sample;
  logic                  in_last_pixel;
  logic                  out_valid;
  logic                  out_ready;
  logic [7:0]            out_red;
  logic [7:0]            out_green;
  logic [7:0]            out_blue;
  logic [7:0]            out_alpha;
  logic                  out_last;
  logic [1:0]            out_alpha_mode;

  // shadow of the block's registers and counts
  logic [FACTOR_W-1:0] red_f;
  logic [FACTOR_W-1:0] green_f;
  logic [FACTOR_W-1:0] blue_f;
  logic [FACTOR_W-1:0] scale_f;
  logic [1:0]          src_sel;
  logic                inv_sel;
  logic [CNT_W-1:0]    opaque_seen;
  logic [CNT_W-1:0]    clear_seen;
  logic [CNT_W-1:0]    partial_seen;

  tinted_t  pending_tints[$];
  dir_row_t dir_rows[$];
  int       mismatches;
  int       send_idle_pct;
  int       recv_stall_pct;
  logic     row_typed;
  tinted_t  row_want;
  setting_t cur_setting;

  texture_tint_alpha_classify dut (.*);

  always #5 clk = ~clk;

  function automatic logic [FACTOR_W-1:0] clamp_unit(logic [CFG_DATA_W-1:0] v);
    return (v > 256) ? FACTOR_W'(256) : FACTOR_W'(v);
  endfunction

  function automatic logic [7:0] scale8(logic [7:0] c, logic [FACTOR_W-1:0] f);
    int unsigned p;
    p = c * f;
    return 8'(p >> 8);
  endfunction

  function automatic void bump(ref logic [CNT_W-1:0] cnt);
    if (cnt < PIXEL_CAP) cnt++;
  endfunction

  // tint one pixel, pick its alpha, update the counts and the image mode
  function automatic tinted_t tint_and_classify(pixel_t p);
    tinted_t         t;
    int unsigned     s;
    int unsigned     a1;
    int unsigned     al;
    longint unsigned total;
    s = inv_sel ? 255 - p.sample : p.sample;
    case (src_sel)
      OPSRC_SCALAR: al = (255 * scale_f) >> 8;
      OPSRC_TEXTURE: begin
        a1 = (p.alpha * scale_f) >> 8;
        al = (a1 * s) / 255;
      end
      default: al = 255;
    endcase
    if (al >= OPAQUE_FLOOR) bump(opaque_seen);
    else if (al <= CLEAR_CEIL) bump(clear_seen);
    else bump(partial_seen);
    t.red   = scale8(p.red, red_f);
    t.green = scale8(p.green, green_f);
    t.blue  = scale8(p.blue, blue_f);
    t.alpha = 8'(al);
    t.last  = p.last;
    t.mode  = MODE_OPAQUE;
    if (p.last) begin
      total = longint'(opaque_seen) + longint'(clear_seen) + longint'(partial_seen);
      if (partial_seen == 0)
        t.mode = (clear_seen != 0) ? MODE_MASK : MODE_OPAQUE;
      else if (longint'(partial_seen) * 50 <= total && longint'(clear_seen) * 1000 >= total)
        t.mode = MODE_MASK;
      else
        t.mode = MODE_BLEND;
      opaque_seen  = '0;
      clear_seen   = '0;
      partial_seen = '0;
    end
    return t;
  endfunction

  function automatic void note_mismatch(string what, logic [7:0] want, logic [7:0] seen);
    $display("%0t: %s expected %0d got %0d", $time, what, want, seen);
    mismatches++;
  endfunction

  // config shadow, expectations and result checks, all at the rising edge
  always @(posedge clk) begin
    tinted_t due;
    tinted_t got;
    if (!rst_n) begin
      red_f        = FACTOR_W'(256);
      green_f      = FACTOR_W'(256);
      blue_f       = FACTOR_W'(256);
      scale_f      = FACTOR_W'(256);
      src_sel      = OPSRC_ONE;
      inv_sel      = 1'b0;
      opaque_seen  = '0;
      clear_seen   = '0;
      partial_seen = '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_RED_FACTOR:   red_f = clamp_unit(cfg_data);
          CFG_GREEN_FACTOR: green_f = clamp_unit(cfg_data);
          CFG_BLUE_FACTOR:  blue_f = clamp_unit(cfg_data);
          CFG_OPACITY_SCL:  scale_f = clamp_unit(cfg_data);
          CFG_OPACITY_SRC:  src_sel = cfg_data[1:0];
          CFG_INVERT_SMP:   inv_sel = cfg_data[0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        due = tint_and_classify(pixel_t'{in_red, in_green, in_blue, in_alpha,
                                         in_opacity_sample, in_last_pixel});
        if (row_typed) due = row_want;
        pending_tints.insert(pending_tints.size(), due);
      end
      if (out_valid && out_ready) begin
        got = {out_red, out_green, out_blue, out_alpha, out_last, out_alpha_mode};
        if (pending_tints.size() == 0) begin
          $display("%0t: word with nothing expected: rgba %0d %0d %0d %0d last %0d mode %0d",
                   $time, out_red, out_green, out_blue, out_alpha, out_last, out_alpha_mode);
          mismatches++;
        end else begin
          due = pending_tints.pop_front();
          if (got.red !== due.red) note_mismatch("red", due.red, got.red);
          if (got.green !== due.green) note_mismatch("green", due.green, got.green);
          if (got.blue !== due.blue) note_mismatch("blue", due.blue, got.blue);
          if (got.alpha !== due.alpha) note_mismatch("alpha", due.alpha, got.alpha);
          if (got.last !== due.last) note_mismatch("last", 8'(due.last), 8'(got.last));
          if (got.mode !== due.mode) note_mismatch("alpha mode", 8'(due.mode), 8'(got.mode));
        end
      end
    end
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic drive_pixel(pixel_t p, logic typed, tinted_t want);
    @(negedge clk);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    {in_red, in_green, in_blue, in_alpha, in_opacity_sample, in_last_pixel} <= p;
    row_typed <= typed;
    row_want  <= want;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // stop sending and wait for every word in flight
  task automatic drain_pipe;
    @(negedge clk);
    in_valid  <= 1'b0;
    cfg_valid <= 1'b0;
    while (pending_tints.size() != 0) @(posedge clk);
  endtask

  task automatic load_setting(setting_t s);
    drain_pipe();
    write_reg(CFG_RED_FACTOR, s.red);
    write_reg(CFG_GREEN_FACTOR, s.green);
    write_reg(CFG_BLUE_FACTOR, s.blue);
    write_reg(CFG_OPACITY_SCL, s.scale);
    write_reg(CFG_OPACITY_SRC, s.src);
    write_reg(CFG_INVERT_SMP, s.inv);
    write_reg(CFG_UNMAPPED_LO, CFG_DATA_W'($urandom_range(511)));
    write_reg(CFG_UNMAPPED_HI, CFG_DATA_W'($urandom_range(511)));
    @(negedge clk);
    cfg_valid <= 1'b0;
    cur_setting = s;
  endtask

  function automatic logic [CFG_DATA_W-1:0] rand_unit();
    return ($urandom_range(3) == 0) ? CFG_DATA_W'($urandom_range(511))
                                    : CFG_DATA_W'($urandom_range(256));
  endfunction

  function automatic setting_t pick_setting(int phase);
    setting_t s;
    s.red   = rand_unit();
    s.green = rand_unit();
    s.blue  = rand_unit();
    s.scale = rand_unit();
    s.src   = CFG_DATA_W'($urandom_range(511));
    s.inv   = CFG_DATA_W'($urandom_range(511));
    case (phase)
      0: begin
        s.scale = 256;
        s.src   = OPSRC_TEXTURE;
        s.inv   = 0;
      end
      1: begin
        s.red   = 0;
        s.green = 0;
        s.blue  = 0;
        s.scale = 0;
      end
      2: begin
        s.red   = 256;
        s.green = 256;
        s.blue  = 256;
        s.scale = 256;
        s.src   = OPSRC_TEXTURE;
        s.inv   = 1;
      end
      4: s.src = OPSRC_SCALAR;
      6: begin
        s.scale = 511;
        s.src   = OPSRC_TEXTURE;
      end
      default: ;
    endcase
    return s;
  endfunction

  // flavor 0 is noise with stray last marks; the others are whole images
  // whose alphas lean toward opaque so that the mask rule gets exercised
  task automatic send_image(int len, int flavor);
    pixel_t p;
    int     roll;
    int     part_pct;
    int     clear_pct;
    part_pct  = (flavor == 1) ? 2 : 0;
    clear_pct = (flavor == 1) ? 4 : (flavor == 2) ? 20 : 0;
    for (int i = 0; i < len; i++) begin
      p.red    = 8'($urandom_range(255));
      p.green  = 8'($urandom_range(255));
      p.blue   = 8'($urandom_range(255));
      p.alpha  = 8'($urandom_range(255));
      p.sample = 8'($urandom_range(255));
      p.last   = ($urandom_range(19) == 0);
      if (flavor != 0) begin
        roll = $urandom_range(99);
        if (roll < part_pct) p.alpha = 8'($urandom_range(249, 6));
        else if (roll < part_pct + clear_pct) p.alpha = 8'($urandom_range(5));
        else p.alpha = 8'($urandom_range(255, 250));
        p.sample = cur_setting.inv[0] ? 8'd0 : 8'd255;
        p.last   = (i == len - 1);
      end
      drive_pixel(p, 1'b0, tinted_t'(0));
    end
  endtask

  function automatic dir_row_t typed_row(setting_t s, pixel_t p, tinted_t want);
    return '{setting: s, pix: p, typed: 1'b1, want: want};
  endfunction

  function automatic dir_row_t open_row(setting_t s, pixel_t p);
    return '{setting: s, pix: p, typed: 1'b0, want: tinted_t'(0)};
  endfunction

  function automatic void add_row(dir_row_t r);
    dir_rows.insert(dir_rows.size(), r);
  endfunction

  initial begin
    int sent;
    int flavor;
    int len;
    bit paused;
    clk               = 1'b0;
    rst_n             = 1'b0;
    cfg_valid         = 1'b0;
    cfg_index         = '0;
    cfg_data          = '0;
    in_valid          = 1'b0;
    in_red            = '0;
    in_green          = '0;
    in_blue           = '0;
    in_alpha          = '0;
    in_opacity_sample = '0;
    in_last_pixel     = 1'b0;
    out_ready         = 1'b0;
    send_idle_pct     = 0;
    recv_stall_pct    = 0;
    row_typed         = 1'b0;
    row_want          = tinted_t'(0);
    cur_setting       = SET_RESET;
    mismatches        = 0;

    add_row(typed_row(SET_RESET, pixel_t'{255, 255, 255, 255, 0, 1'b0},
                      tinted_t'{255, 255, 255, 255, 1'b0, MODE_OPAQUE}));
    add_row(typed_row(SET_RESET, pixel_t'{0, 0, 0, 0, 255, 1'b1},
                      tinted_t'{0, 0, 0, 255, 1'b1, MODE_OPAQUE}));
    add_row(typed_row(SET_ZERO, pixel_t'{255, 255, 255, 255, 255, 1'b0},
                      tinted_t'{0, 0, 0, 0, 1'b0, MODE_OPAQUE}));
    add_row(typed_row(SET_ZERO, pixel_t'{1, 128, 200, 255, 0, 1'b1},
                      tinted_t'{0, 0, 0, 0, 1'b1, MODE_MASK}));
    // oversized factors and scale saturate to unity
    add_row(typed_row(SET_SAT, pixel_t'{255, 255, 255, 255, 255, 1'b0},
                      tinted_t'{255, 255, 255, 255, 1'b0, MODE_OPAQUE}));
    add_row(typed_row(SET_SAT, pixel_t'{128, 64, 1, 255, 0, 1'b0},
                      tinted_t'{128, 64, 1, 0, 1'b0, MODE_OPAQUE}));
    add_row(open_row(SET_SAT, pixel_t'{10, 20, 30, 255, 128, 1'b0}));
    add_row(open_row(SET_SAT, pixel_t'{0, 0, 0, 0, 255, 1'b1}));
    // inverted sample, alphas on both sides of the class thresholds
    add_row(open_row(SET_HALF_INV, pixel_t'{255, 2, 3, 255, 0, 1'b0}));
    add_row(open_row(SET_HALF_INV, pixel_t'{100, 200, 255, 200, 255, 1'b0}));
    add_row(open_row(SET_HALF_INV, pixel_t'{0, 0, 0, 255, 250, 1'b0}));
    add_row(open_row(SET_HALF_INV, pixel_t'{0, 0, 0, 255, 4, 1'b0}));
    add_row(open_row(SET_HALF_INV, pixel_t'{0, 0, 0, 255, 6, 1'b0}));
    add_row(open_row(SET_HALF_INV, pixel_t'{0, 0, 0, 255, 249, 1'b1}));
    // spare opacity source behaves as full opacity
    add_row(typed_row(SET_SPARE_SRC, pixel_t'{255, 255, 255, 0, 0, 1'b0},
                      tinted_t'{255, 0, 255, 255, 1'b0, MODE_OPAQUE}));
    add_row(open_row(SET_SPARE_SRC, pixel_t'{17, 255, 100, 0, 0, 1'b1}));
    add_row(typed_row(SET_SCALAR, pixel_t'{255, 255, 255, 255, 0, 1'b1},
                      tinted_t'{255, 255, 255, 127, 1'b1, MODE_BLEND}));
    add_row(open_row(SET_SCALAR, pixel_t'{0, 0, 0, 0, 0, 1'b0}));

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].setting != cur_setting) load_setting(dir_rows[i].setting);
      drive_pixel(dir_rows[i].pix, dir_rows[i].typed, dir_rows[i].want);
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 49; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 49; end
        default: begin send_idle_pct = 27; recv_stall_pct = 27; end
      endcase
      load_setting(pick_setting(phase));
      sent   = 0;
      paused = 1'b0;
      while (sent < PHASE_PIXELS) begin
        flavor = $urandom_range(3);
        len    = (flavor == 1) ? $urandom_range(150, 50) : $urandom_range(40, 1);
        send_image(len, flavor);
        sent += len;
        if (!paused && sent >= PHASE_PIXELS / 2) begin
          drain_pipe();
          paused = 1'b1;
        end
      end
    end

    drain_pipe();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending_tints.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

### filelist.f
hw/rtl/tac_pkg.sv
hw/rtl/tac_front.sv
hw/rtl/tac_fifo.sv
hw/rtl/tac_back.sv
hw/rtl/texture_tint_alpha_classify.sv
verif/texture_tint_alpha_classify_tb.sv
